// File: hw/rtl/bct_pkg.sv
`default_nettype none
package bct_pkg;

  localparam int POSITIONS  = 16;
  localparam int MAX_LEVELS = 64;

  localparam int POS_W   = $clog2(POSITIONS);
  localparam int TL_W    = $clog2(POSITIONS + 1);
  localparam int LEVEL_W = $clog2(MAX_LEVELS + 1);
  localparam int MARK_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  localparam logic [1:0] ACT_FIX  = 2'd0;
  localparam logic [1:0] ACT_PUSH = 2'd1;
  localparam logic [1:0] ACT_POP  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CONFLICT = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_UNWIND,
    S_CLEAR,
    S_WAIT
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/bijection_conflict_trail.sv
// fix, push, error and zero-level pop items pass from the idle state to the wait state, then out
// a pop reads its level mark in the mark state, then for each trail entry does a trail read
// and a clear step through the shared unwind step, and goes from the unwind step to the wait state
// no new item is taken until the result is loaded into the output register
// rst is synchronous: position and value ownership flags, trail length and level
// count clear at once; trail and level mark storage are written before use
`default_nettype none
module bijection_conflict_trail (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                action,
  input  wire logic [bct_pkg::POS_W-1:0] position,
  input  wire logic [bct_pkg::POS_W-1:0] value,
  input  wire logic [bct_pkg::LEVEL_W-1:0] scopes,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     status,
  output logic [bct_pkg::POS_W-1:0]      partner_position,
  output logic [bct_pkg::LEVEL_W-1:0]    level
);
  import bct_pkg::*;

  state_t state, state_next;

  // assignment store
  logic [POSITIONS-1:0] pv_set;
  logic [POS_W-1:0]     position_value [POSITIONS];
  logic [POSITIONS-1:0] vo_set;
  logic [POS_W-1:0]     value_owner [POSITIONS];
  logic [POS_W-1:0]     trail [POSITIONS];
  logic [TL_W-1:0]      trail_length;
  logic [LEVEL_W-1:0]   depth_count;

  // level marks memory
  logic [TL_W-1:0]      level_marks [MAX_LEVELS];
  logic [TL_W-1:0]      mark_rd;
  logic [TL_W-1:0]      mark;
  logic [LEVEL_W-1:0]   target;
  logic [POS_W-1:0]     unwind_pos;

  // pending result
  logic [1:0]           res_status;
  logic [POS_W-1:0]     res_partner;

  logic                 accept;
  logic                 out_free;
  logic                 fix_ok;
  logic                 push_ok;
  logic                 pop_bad;
  logic [LEVEL_W-1:0]   target_c;
  logic [TL_W-1:0]      tl_m1;
  logic                 more;
  logic [POS_W-1:0]     clear_val;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  assign fix_ok   = ({1'b0, position} < (POS_W+1)'(POSITIONS))
                 && ({1'b0, value} < (POS_W+1)'(POSITIONS))
                 && !pv_set[position]
                 && (trail_length < TL_W'(POSITIONS));
  assign push_ok  = depth_count < LEVEL_W'(MAX_LEVELS);
  assign pop_bad  = scopes > depth_count;
  assign target_c = depth_count - scopes;
  assign tl_m1    = trail_length - 1'b1;
  assign more     = (trail_length > mark) && (trail_length != '0);
  assign clear_val = position_value[unwind_pos];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_POP && !pop_bad && scopes != '0) begin
            state_next = S_MARK;
          end else begin
            state_next = S_WAIT;
          end
        end
      end
      S_MARK:   state_next = S_UNWIND;
      S_UNWIND: state_next = more ? S_CLEAR : S_WAIT;
      S_CLEAR:  state_next = S_UNWIND;
      S_WAIT:   state_next = out_free ? S_IDLE : S_WAIT;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // level marks: one write port, registered read at the pop target
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && action == ACT_PUSH && push_ok) begin
      level_marks[depth_count[MARK_W-1:0]] <= trail_length;
    end
    mark_rd <= level_marks[target_c[MARK_W-1:0]];
  end

  // trail and assignment payload, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && action == ACT_FIX && fix_ok) begin
      trail[trail_length[POS_W-1:0]] <= position;
      position_value[position]       <= value;
      if (!vo_set[value]) begin
        value_owner[value] <= position;
      end
    end
  end

  // control state and the sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pv_set       <= '0;
      vo_set       <= '0;
      trail_length <= '0;
      depth_count  <= '0;
      out_valid    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            target <= target_c;
            case (action)
              ACT_FIX: begin
                if (fix_ok) begin
                  trail_length     <= trail_length + 1'b1;
                  pv_set[position] <= 1'b1;
                  if (vo_set[value]) begin
                    res_status  <= ST_CONFLICT;
                    res_partner <= value_owner[value];
                  end else begin
                    res_status    <= ST_OK;
                    res_partner   <= '0;
                    vo_set[value] <= 1'b1;
                  end
                end else begin
                  res_status  <= ST_ERROR;
                  res_partner <= '0;
                end
              end
              ACT_PUSH: begin
                res_partner <= '0;
                if (push_ok) begin
                  res_status  <= ST_OK;
                  depth_count <= depth_count + 1'b1;
                end else begin
                  res_status <= ST_ERROR;
                end
              end
              ACT_POP: begin
                res_partner <= '0;
                if (pop_bad) begin
                  res_status <= ST_ERROR;
                end else begin
                  res_status <= ST_OK;
                end
              end
              default: begin
                res_status  <= ST_ERROR;
                res_partner <= '0;
              end
            endcase
          end
        end
        S_MARK: mark <= mark_rd;
        // take the newest trail entry, or finish the pop
        S_UNWIND: begin
          if (more) begin
            unwind_pos   <= trail[tl_m1[POS_W-1:0]];
            trail_length <= tl_m1;
          end else begin
            depth_count <= target;
          end
        end
        // release the position and the value it owned
        S_CLEAR: begin
          if (pv_set[unwind_pos]) begin
            pv_set[unwind_pos] <= 1'b0;
            if (vo_set[clear_val] && value_owner[clear_val] == unwind_pos) begin
              vo_set[clear_val] <= 1'b0;
            end
          end
        end
        default: ;
      endcase

      // output register
      if (state == S_WAIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WAIT && out_free) begin
      status           <= res_status;
      partner_position <= res_partner;
      level            <= depth_count;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bct_checker.sv
`default_nettype none
module bct_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [1:0]                   status,
  input wire logic [bct_pkg::POS_W-1:0]    partner_position,
  input wire logic [bct_pkg::LEVEL_W-1:0]  level
);
  import bct_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // the block is busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer in without a busy cycle");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_CONFLICT || status == ST_ERROR))
    else $error("status code out of range");

  // partner only named on conflict
  a_partner: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_CONFLICT |-> partner_position == '0)
    else $error("partner set without conflict");

  a_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level <= LEVEL_W'(MAX_LEVELS))
    else $error("level beyond stack depth");

endmodule

bind bijection_conflict_trail bct_checker u_bct_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .status           (status),
  .partner_position (partner_position),
  .level            (level)
);
`default_nettype wire
